// ----- sv/crc16_serial_frame_builder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// CRC16 serial frame builder assertion macros
// Shared concurrent assertion wrappers; the user module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef CRC16_SERIAL_FRAME_BUILDER_UNIT_MACROS_SVH
`define CRC16_SERIAL_FRAME_BUILDER_UNIT_MACROS_SVH

// check outside reset
`define CRCSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("crc16 frame builder check failed");

// check on every edge, reset included
`define CRCSF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("crc16 frame builder check failed");

`endif

// ----- sv/crcsf_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC16 serial frame builder package
// Frame constants, byte slot codes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcsf_pkg;

    localparam int PAYLOAD_COUNT = 32;
    localparam int EFF_COUNT_INT = (PAYLOAD_COUNT < 2) ? 2 :
                                   ((PAYLOAD_COUNT > 255) ? 255 : PAYLOAD_COUNT);

    localparam logic [7:0]  EFF_COUNT = EFF_COUNT_INT[7:0];
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  HDR_SYNC0 = 8'hA5;
    localparam logic [7:0]  HDR_SYNC1 = 8'h5A;
    localparam logic [7:0]  HDR_PAD   = 8'h00;
    localparam logic [7:0]  TRAILER   = 8'hFF;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        SLOT_SYNC0   = 3'd0,
        SLOT_SYNC1   = 3'd1,
        SLOT_COUNT   = 3'd2,
        SLOT_PAD     = 3'd3,
        SLOT_PAYLOAD = 3'd4,
        SLOT_CRC_HI  = 3'd5,
        SLOT_CRC_LO  = 3'd6,
        SLOT_TRAILER = 3'd7
    } slot_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input byte_t data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    localparam logic [15:0] HDR_CRC =
        crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, HDR_SYNC0), HDR_SYNC1),
                          EFF_COUNT), HDR_PAD);

endpackage

`default_nettype wire

// ----- sv/crcsf_if.sv -----
// ----------------------------------------------------------------------------
// CRC16 serial frame builder channels
// Valid/ready item channels for source bytes and frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

interface crcsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_of_frame;

    modport source (output valid, output frame_byte, output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- sv/crc16_serial_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// CRC16 serial frame builder
// Turns source bytes into framed requests: header, one payload bit per item,
// CRC-16/MODBUS high and low byte, trailer.
// ----------------------------------------------------------------------------
//  channel    | direction | payload
//  -----------+-----------+----------------------------------
//  item_in    | sink      | random_byte[7:0]
//  item_out   | source    | frame_byte[7:0], last_of_frame
//
//  One frame byte leaves per cycle while item_out is ready; an input item
//  yields one byte mid-frame, five on a frame's first item, four on its last,
//  set by the burst register that holds one item's results while they drain.
//  A new item is taken in the cycle its predecessor's final byte is taken.
//  Reset clears the frame position and the burst register; CRC starts at FFFF.
//  Output stalls hold the burst and the input ready low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc16_serial_frame_builder_unit_macros.svh"

module crc16_serial_frame_builder_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    crcsf_in_if.sink    item_in,
    crcsf_out_if.source item_out
);
    import crcsf_pkg::*;

    logic        valid_reg;
    logic        hdr_reg;
    logic        last_reg;
    logic        bit_reg;
    logic [15:0] crc_out_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  pos_reg;
    logic [15:0] crc_reg;

    logic        in_acc;
    logic        out_acc;
    logic        done;
    slot_t       slot;
    logic [2:0]  slot_code;
    logic [2:0]  end_code;
    logic [7:0]  pos_inc;
    logic        close_frame;
    logic [15:0] crc_start;
    logic [15:0] crc_new;
    byte_t       out_byte;

    assign slot_code = hdr_reg ? idx_reg : (idx_reg + 3'd4);
    assign slot      = slot_t'(slot_code);
    assign end_code  = last_reg ? 3'(SLOT_TRAILER) : 3'(SLOT_PAYLOAD);
    assign done      = (slot_code == end_code);

    assign item_in.ready  = !valid_reg || (item_out.ready && done);
    assign in_acc         = item_in.valid && item_in.ready;
    assign out_acc        = item_out.valid && item_out.ready;

    assign pos_inc     = pos_reg + 8'd1;
    assign close_frame = (pos_inc >= EFF_COUNT);
    assign crc_start   = (pos_reg == 8'd0) ? HDR_CRC : crc_reg;
    assign crc_new     = crc_feed(crc_start, {7'd0, item_in.random_byte[0]});

    always_comb
    begin
        unique case (slot)
            SLOT_SYNC0:   out_byte = HDR_SYNC0;
            SLOT_SYNC1:   out_byte = HDR_SYNC1;
            SLOT_COUNT:   out_byte = EFF_COUNT;
            SLOT_PAD:     out_byte = HDR_PAD;
            SLOT_PAYLOAD: out_byte = {7'd0, bit_reg};
            SLOT_CRC_HI:  out_byte = crc_out_reg[15:8];
            SLOT_CRC_LO:  out_byte = crc_out_reg[7:0];
            SLOT_TRAILER: out_byte = TRAILER;
            default:      out_byte = TRAILER;
        endcase
    end

    assign item_out.valid         = valid_reg;
    assign item_out.frame_byte    = out_byte;
    assign item_out.last_of_frame = (slot == SLOT_TRAILER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
            pos_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            hdr_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= 3'd0;
                hdr_reg   <= (pos_reg == 8'd0);
                last_reg  <= close_frame;
                pos_reg   <= close_frame ? 8'd0 : pos_inc;
                crc_reg   <= close_frame ? CRC_INIT : crc_new;
            end
            else if (out_acc)
            begin
                if (done)
                begin
                    valid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            bit_reg     <= item_in.random_byte[0];
            crc_out_reg <= crc_new;
        end
    end

    `CRCSF_ASSERT(a_in_then_out, in_acc |=> item_out.valid)
    `CRCSF_ASSERT(a_trailer_closed, (out_acc && item_out.last_of_frame) |-> (pos_reg == 8'd0))
    `CRCSF_ASSERT(a_trailer_byte, item_out.last_of_frame |-> (item_out.frame_byte == TRAILER))
    `CRCSF_ASSERT_ALWAYS(a_idle_ready, !valid_reg |-> item_in.ready)

endmodule

`default_nettype wire
